// ----- hdl/gab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_pkg
// Shared types, codes and the step table of the gammatone band filter.
// ----------------------------------------------------------------------------
package gab_pkg;

    localparam int STATE_FRAC = 8;
    localparam int STEPS      = 28;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_FLUSH   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_COS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_SIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SKIP = 3'd6;

    // multiplier phases of one step
    localparam logic [1:0] PH_LO  = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_RND = 2'd2;
    localparam logic [1:0] PH_ACC = 2'd3;

    // operand A
    localparam logic [4:0] A_K    = 5'd0;
    localparam logic [4:0] A_K2   = 5'd1;
    localparam logic [4:0] A_K3   = 5'd2;
    localparam logic [4:0] A_OSCR = 5'd3;
    localparam logic [4:0] A_OSCI = 5'd4;
    localparam logic [4:0] A_SMP  = 5'd5;
    localparam logic [4:0] A_PR0  = 5'd6;
    localparam logic [4:0] A_PR1  = 5'd7;
    localparam logic [4:0] A_PR2  = 5'd8;
    localparam logic [4:0] A_PR3  = 5'd9;
    localparam logic [4:0] A_PI0  = 5'd10;
    localparam logic [4:0] A_PI1  = 5'd11;
    localparam logic [4:0] A_PI2  = 5'd12;
    localparam logic [4:0] A_PI3  = 5'd13;
    localparam logic [4:0] A_UR   = 5'd14;
    localparam logic [4:0] A_UI   = 5'd15;
    localparam logic [4:0] A_W    = 5'd16;

    // operand C
    localparam logic [3:0] C_K    = 4'd0;
    localparam logic [3:0] C_K2   = 4'd1;
    localparam logic [3:0] C_K3   = 4'd2;
    localparam logic [3:0] C_K4   = 4'd3;
    localparam logic [3:0] C_PCOS = 4'd4;
    localparam logic [3:0] C_PSIN = 4'd5;
    localparam logic [3:0] C_PHR  = 4'd6;
    localparam logic [3:0] C_PHI  = 4'd7;
    localparam logic [3:0] C_OSCR = 4'd8;
    localparam logic [3:0] C_OSCI = 4'd9;
    localparam logic [3:0] C_GAIN = 4'd10;
    localparam logic [3:0] C_RCOS = 4'd11;
    localparam logic [3:0] C_RSIN = 4'd12;

    localparam logic [1:0] B_ZERO = 2'd0;
    localparam logic [1:0] B_ACC  = 2'd1;
    localparam logic [1:0] B_PR0  = 2'd2;
    localparam logic [1:0] B_PI0  = 2'd3;

    localparam logic [1:0] SC_1 = 2'd0;
    localparam logic [1:0] SC_4 = 2'd1;
    localparam logic [1:0] SC_6 = 2'd2;

    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_K2   = 4'd1;
    localparam logic [3:0] D_K3   = 4'd2;
    localparam logic [3:0] D_K4   = 4'd3;
    localparam logic [3:0] D_PHR  = 4'd4;
    localparam logic [3:0] D_PHI  = 4'd5;
    localparam logic [3:0] D_P0R  = 4'd6;
    localparam logic [3:0] D_P0I  = 4'd7;
    localparam logic [3:0] D_UR   = 4'd8;
    localparam logic [3:0] D_UI   = 4'd9;
    localparam logic [3:0] D_W    = 4'd10;
    localparam logic [3:0] D_OUT  = 4'd11;
    localparam logic [3:0] D_NR   = 4'd12;
    localparam logic [3:0] D_NI   = 4'd13;

    typedef struct packed {
        logic [4:0] a_sel;
        logic [3:0] c_sel;
        logic [1:0] base_sel;
        logic [1:0] scale;
        logic       sub;
        logic [3:0] dest;
    } gab_uop_t;

    typedef struct packed {
        logic       load_in;
        logic       zero_in;
        logic       restart;
        logic       run;
        logic [1:0] phase;
        gab_uop_t   uop;
        logic       commit;
        logic       load_out;
    } gab_cmd_t;

    typedef struct packed {
        logic skip_zero;
    } gab_stat_t;

    function automatic gab_uop_t mk(input logic [4:0] a, input logic [3:0] c,
                                    input logic [1:0] b, input logic [1:0] s,
                                    input logic sb, input logic [3:0] d);
        gab_uop_t u;
        u.a_sel    = a;
        u.c_sel    = c;
        u.base_sel = b;
        u.scale    = s;
        u.sub      = sb;
        u.dest     = d;
        return u;
    endfunction

    function automatic gab_uop_t ucode(input logic [STEP_W-1:0] step);
        gab_uop_t u;
        case (step)
            5'd0:  u = mk(A_K,    C_K,    B_ZERO, SC_1, 1'b0, D_K2);
            5'd1:  u = mk(A_K2,   C_K,    B_ZERO, SC_1, 1'b0, D_K3);
            5'd2:  u = mk(A_K3,   C_K,    B_ZERO, SC_1, 1'b0, D_K4);
            5'd3:  u = mk(A_OSCR, C_PCOS, B_ZERO, SC_1, 1'b0, D_NONE);
            5'd4:  u = mk(A_OSCI, C_PSIN, B_ACC,  SC_1, 1'b1, D_PHR);
            5'd5:  u = mk(A_OSCR, C_PSIN, B_ZERO, SC_1, 1'b0, D_NONE);
            5'd6:  u = mk(A_OSCI, C_PCOS, B_ACC,  SC_1, 1'b0, D_PHI);
            5'd7:  u = mk(A_SMP,  C_PHR,  B_ZERO, SC_1, 1'b0, D_NONE);
            5'd8:  u = mk(A_PR0,  C_K,    B_ACC,  SC_4, 1'b0, D_NONE);
            5'd9:  u = mk(A_PR1,  C_K2,   B_ACC,  SC_6, 1'b1, D_NONE);
            5'd10: u = mk(A_PR2,  C_K3,   B_ACC,  SC_4, 1'b0, D_NONE);
            5'd11: u = mk(A_PR3,  C_K4,   B_ACC,  SC_1, 1'b1, D_P0R);
            5'd12: u = mk(A_SMP,  C_PHI,  B_ZERO, SC_1, 1'b0, D_NONE);
            5'd13: u = mk(A_PI0,  C_K,    B_ACC,  SC_4, 1'b0, D_NONE);
            5'd14: u = mk(A_PI1,  C_K2,   B_ACC,  SC_6, 1'b1, D_NONE);
            5'd15: u = mk(A_PI2,  C_K3,   B_ACC,  SC_4, 1'b0, D_NONE);
            5'd16: u = mk(A_PI3,  C_K4,   B_ACC,  SC_1, 1'b1, D_P0I);
            5'd17: u = mk(A_PR1,  C_K,    B_PR0,  SC_4, 1'b0, D_NONE);
            5'd18: u = mk(A_PR2,  C_K2,   B_ACC,  SC_1, 1'b0, D_UR);
            5'd19: u = mk(A_PI1,  C_K,    B_PI0,  SC_4, 1'b0, D_NONE);
            5'd20: u = mk(A_PI2,  C_K2,   B_ACC,  SC_1, 1'b0, D_UI);
            5'd21: u = mk(A_UR,   C_OSCR, B_ZERO, SC_1, 1'b0, D_NONE);
            5'd22: u = mk(A_UI,   C_OSCI, B_ACC,  SC_1, 1'b1, D_W);
            5'd23: u = mk(A_W,    C_GAIN, B_ZERO, SC_1, 1'b0, D_OUT);
            5'd24: u = mk(A_OSCR, C_RCOS, B_ZERO, SC_1, 1'b0, D_NONE);
            5'd25: u = mk(A_OSCI, C_RSIN, B_ACC,  SC_1, 1'b1, D_NR);
            5'd26: u = mk(A_OSCI, C_RCOS, B_ZERO, SC_1, 1'b0, D_NONE);
            5'd27: u = mk(A_OSCR, C_RSIN, B_ACC,  SC_1, 1'b0, D_NI);
            default: u = mk(A_K, C_K, B_ZERO, SC_1, 1'b0, D_NONE);
        endcase
        return u;
    endfunction

endpackage

// ----- hdl/gab_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_datapath
// Config registers, filter state and one shared rounding multiplier with a
// saturating accumulator, driven step by step by the controller.
// ----------------------------------------------------------------------------
module gab_datapath
    import gab_pkg::*;
#(
    parameter int STATE_WIDTH = 48,
    parameter int COEF_FRAC   = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [15:0]          s_tdata,
    input  gab_cmd_t             cmd,
    output gab_stat_t            stat,
    output logic [31:0]          m_tdata
);

    localparam logic [63:0] RND    = 64'd1 << (COEF_FRAC - 1);
    localparam int          HS_SH  = 32 - COEF_FRAC;
    localparam logic [63:0] HI_LIM = {64{1'b1}} >> HS_SH;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< COEF_FRAC;
    localparam logic signed [63:0] ST_MAX = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] ST_MIN = -ST_MAX - 64'sd1;
    localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (a < -64'sd2147483648) return 32'sh80000000;
        return a[31:0];
    endfunction

    // configuration
    logic signed [31:0] rcos_reg, rsin_reg, pcos_reg, psin_reg;
    logic [29:0]        k_reg;
    logic [31:0]        gain_reg;
    logic [15:0]        oskip_reg;

    // state
    logic signed [31:0]            oscr_reg, osci_reg;
    logic signed [STATE_WIDTH-1:0] pr_reg [4];
    logic signed [STATE_WIDTH-1:0] pi_reg [4];
    logic [15:0]                   skip_reg;

    // working values
    logic signed [15:0]            smp_reg;
    logic signed [63:0]            k2_reg, k3_reg, k4_reg;
    logic signed [31:0]            phr_reg, phi_reg, nr_reg, ni_reg;
    logic signed [STATE_WIDTH-1:0] p0r_reg, p0i_reg;
    logic signed [63:0]            ur_reg, ui_reg, w_reg, acc_reg, f_reg;
    logic [63:0]                   lo_reg, hi_reg;
    logic signed [31:0]            res_reg, out_reg;

    logic signed [63:0] a_val;
    logic signed [33:0] c_val;
    logic [63:0]        am;
    logic [32:0]        cm;
    logic [31:0]        mul_a;
    logic [64:0]        mul_p;
    logic               neg;
    logic [63:0]        low, hs, mag_f;
    logic [64:0]        hsum;
    logic signed [63:0] f_next;
    logic signed [66:0] f67, prod67;
    logic signed [63:0] term, base, acc_next;
    logic [63:0]        acc_mag, rq;
    logic signed [63:0] rsh;

    always_comb begin
        case (cmd.uop.a_sel)
            A_K:     a_val = 64'(signed'({1'b0, k_reg}));
            A_K2:    a_val = k2_reg;
            A_K3:    a_val = k3_reg;
            A_OSCR:  a_val = 64'(oscr_reg);
            A_OSCI:  a_val = 64'(osci_reg);
            A_SMP:   a_val = 64'(smp_reg) <<< STATE_FRAC;
            A_PR0:   a_val = 64'(pr_reg[0]);
            A_PR1:   a_val = 64'(pr_reg[1]);
            A_PR2:   a_val = 64'(pr_reg[2]);
            A_PR3:   a_val = 64'(pr_reg[3]);
            A_PI0:   a_val = 64'(pi_reg[0]);
            A_PI1:   a_val = 64'(pi_reg[1]);
            A_PI2:   a_val = 64'(pi_reg[2]);
            A_PI3:   a_val = 64'(pi_reg[3]);
            A_UR:    a_val = ur_reg;
            A_UI:    a_val = ui_reg;
            A_W:     a_val = w_reg;
            default: a_val = '0;
        endcase
        case (cmd.uop.c_sel)
            C_K:     c_val = 34'(signed'({1'b0, k_reg}));
            C_K2:    c_val = k2_reg[33:0];
            C_K3:    c_val = k3_reg[33:0];
            C_K4:    c_val = k4_reg[33:0];
            C_PCOS:  c_val = 34'(pcos_reg);
            C_PSIN:  c_val = 34'(psin_reg);
            C_PHR:   c_val = 34'(phr_reg);
            C_PHI:   c_val = 34'(phi_reg);
            C_OSCR:  c_val = 34'(oscr_reg);
            C_OSCI:  c_val = 34'(osci_reg);
            C_GAIN:  c_val = signed'({2'b00, gain_reg});
            C_RCOS:  c_val = 34'(rcos_reg);
            C_RSIN:  c_val = 34'(rsin_reg);
            default: c_val = '0;
        endcase
    end

    assign am    = a_val[63] ? 64'(-a_val) : 64'(a_val);
    assign cm    = c_val[33] ? 33'(-c_val) : c_val[32:0];
    assign neg   = a_val[63] ^ c_val[33];
    assign mul_a = (cmd.phase == PH_LO) ? am[31:0] : am[63:32];
    assign mul_p = 65'(mul_a) * 65'(cm);

    // rounded magnitude from the two partial products
    always_comb begin
        low   = (lo_reg + RND) >> COEF_FRAC;
        hs    = hi_reg << HS_SH;
        hsum  = 65'(hs) + 65'(low);
        mag_f = (hi_reg > HI_LIM || hsum[64]) ? {64{1'b1}} : hsum[63:0];
        if (neg) begin
            f_next = mag_f[63] ? MIN64 : -signed'(mag_f);
        end else begin
            f_next = mag_f[63] ? MAX64 : signed'(mag_f);
        end
    end

    always_comb begin
        f67 = 67'(f_reg);
        case (cmd.uop.scale)
            SC_4:    prod67 = f67 <<< 2;
            SC_6:    prod67 = (f67 <<< 2) + (f67 <<< 1);
            default: prod67 = f67;
        endcase
        if (prod67 > 67'(MAX64)) begin
            term = MAX64;
        end else if (prod67 < 67'(MIN64)) begin
            term = MIN64;
        end else begin
            term = prod67[63:0];
        end
        if (cmd.uop.sub) term = (term == MIN64) ? MAX64 : -term;
        case (cmd.uop.base_sel)
            B_ACC:   base = acc_reg;
            B_PR0:   base = 64'(pr_reg[0]);
            B_PI0:   base = 64'(pi_reg[0]);
            default: base = '0;
        endcase
        acc_next = sat_add(base, term);
        acc_mag  = acc_next[63] ? 64'(-acc_next) : 64'(acc_next);
        rq       = (acc_mag >> STATE_FRAC) + 64'(acc_mag[STATE_FRAC-1]);
        rsh      = acc_next[63] ? -signed'(rq) : signed'(rq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcos_reg  <= ONE_Q;
            rsin_reg  <= '0;
            pcos_reg  <= ONE_Q;
            psin_reg  <= '0;
            k_reg     <= '0;
            gain_reg  <= 32'(ONE_Q);
            oskip_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROT_COS:     rcos_reg  <= cfg_data;
                REG_ROT_SIN:     rsin_reg  <= cfg_data;
                REG_PHASE_COS:   pcos_reg  <= cfg_data;
                REG_PHASE_SIN:   psin_reg  <= cfg_data;
                REG_POLE_RADIUS: k_reg     <= cfg_data[29:0];
                REG_OUTPUT_GAIN: gain_reg  <= cfg_data;
                REG_OUTPUT_SKIP: oskip_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            oscr_reg <= ONE_Q;
            osci_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                pr_reg[i] <= '0;
                pi_reg[i] <= '0;
            end
            skip_reg <= aresetn ? oskip_reg : 16'd0;
        end else if (cmd.commit) begin
            for (int i = 3; i >= 1; i--) begin
                pr_reg[i] <= pr_reg[i-1];
                pi_reg[i] <= pi_reg[i-1];
            end
            pr_reg[0] <= p0r_reg;
            pi_reg[0] <= p0i_reg;
            oscr_reg  <= nr_reg;
            osci_reg  <= ni_reg;
            if (skip_reg != 16'd0) skip_reg <= skip_reg - 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) smp_reg <= cmd.zero_in ? 16'sd0 : signed'(s_tdata);
        if (cmd.load_out) out_reg <= res_reg;
        if (cmd.run) begin
            case (cmd.phase)
                PH_LO:  lo_reg <= mul_p[63:0];
                PH_HI:  hi_reg <= mul_p[63:0];
                PH_RND: f_reg  <= f_next;
                default: begin
                    acc_reg <= acc_next;
                    case (cmd.uop.dest)
                        D_K2:  k2_reg  <= acc_next;
                        D_K3:  k3_reg  <= acc_next;
                        D_K4:  k4_reg  <= acc_next;
                        D_PHR: phr_reg <= sat32(acc_next);
                        D_PHI: phi_reg <= sat32(acc_next);
                        D_P0R: begin
                            if (acc_next > ST_MAX) p0r_reg <= ST_MAX[STATE_WIDTH-1:0];
                            else if (acc_next < ST_MIN) p0r_reg <= ST_MIN[STATE_WIDTH-1:0];
                            else p0r_reg <= acc_next[STATE_WIDTH-1:0];
                        end
                        D_P0I: begin
                            if (acc_next > ST_MAX) p0i_reg <= ST_MAX[STATE_WIDTH-1:0];
                            else if (acc_next < ST_MIN) p0i_reg <= ST_MIN[STATE_WIDTH-1:0];
                            else p0i_reg <= acc_next[STATE_WIDTH-1:0];
                        end
                        D_UR:  ur_reg  <= acc_next;
                        D_UI:  ui_reg  <= acc_next;
                        D_W:   w_reg   <= acc_next;
                        D_OUT: res_reg <= sat32(rsh);
                        D_NR:  nr_reg  <= sat32(acc_next);
                        D_NI:  ni_reg  <= sat32(acc_next);
                        default: ;
                    endcase
                end
            endcase
        end
    end

    assign stat.skip_zero = (skip_reg == 16'd0);
    assign m_tdata        = out_reg;

endmodule

// ----- hdl/gab_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gab_ctrl
// Sequencer: takes items, walks the step table four phases a step, and
// hands results to the output register.
// ----------------------------------------------------------------------------
module gab_ctrl
    import gab_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  gab_stat_t  stat,
    output gab_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        phase_reg, phase_next;
    logic              mv_reg, mv_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;

    always_comb begin
        cmd        = '0;
        cmd.phase  = phase_reg;
        cmd.uop    = ucode(step_reg);
        cmd.run    = (state_reg == ST_RUN);
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        mv_next    = mv_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == KIND_RESTART) begin
                        cmd.restart = 1'b1;
                    end else if (s_tuser == KIND_SAMPLE || s_tuser == KIND_FLUSH) begin
                        cmd.load_in = 1'b1;
                        cmd.zero_in = (s_tuser == KIND_FLUSH);
                        state_next  = ST_RUN;
                        step_next   = '0;
                        phase_next  = PH_LO;
                    end
                end
            end
            ST_RUN: begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == PH_ACC) begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_W'(STEPS - 1)) state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!stat.skip_zero) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else if (!mv_reg || m_tready) begin
                    cmd.commit   = 1'b1;
                    cmd.load_out = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            phase_reg <= PH_LO;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

// ----- hdl/gammatone_allpole_band_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gammatone_allpole_band_filter
// One band of a fourth-order all-pole gammatone filter with oscillator
// demodulation, numerator, remodulation, gain and saturation.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  s_      | in        | tdata: sample[15:0]; tuser: kind[1:0]
//  m_      | out       | tdata: value[31:0]
//  cfg_    | in        | index[2:0], data[31:0]
//
// A sample or flush item is accepted, runs 28 products on the one shared
// 32x33 multiplier in low, high, round and accumulate phases, and commits.
// A restart or unused kind is taken in idle. Reset clears the state at once.
// A result waits in the output register; a new item is taken meanwhile, and
// the commit holds only if that register is still full.
module gammatone_allpole_band_filter
    import gab_pkg::*;
#(
    parameter int STATE_WIDTH = 48,
    parameter int COEF_FRAC   = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // sample[15:0]
    input  logic [1:0]           s_tuser,   // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // value[31:0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    gab_cmd_t  cmd;
    gab_stat_t stat;

    assign cfg_ready = 1'b1;

    gab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gab_datapath #(
        .STATE_WIDTH (STATE_WIDTH),
        .COEF_FRAC   (COEF_FRAC)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_restart_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_RESTART |=> s_tready)
        else $error("restart did not complete in one cycle");

    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_SAMPLE || s_tuser == KIND_FLUSH)
        |=> !s_tready)
        else $error("sample item did not start processing");

    a_result_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in progress");
`endif

endmodule

// ----- dv/tb_gammatone_allpole_band_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gammatone_allpole_band_filter
// Self-checking bench for one gammatone band. A fixed-point predictor tracks
// the oscillator, pole states and skip count for every accepted item and
// queues the expected band value. Directed items cover the field extremes,
// flush, restart, unused kind and skipped results. Random phases then run
// under varied register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_gammatone_allpole_band_filter;
    import gab_pkg::*;

    localparam int          FRAC        = 30;
    localparam longint      I64MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      I64MIN      = 64'sh8000_0000_0000_0000;
    localparam longint      I32MAX      = 64'sd2147483647;
    localparam longint      POLE_LIM    = (64'sd1 <<< 47) - 1;
    localparam longint      ONE_Q       = 64'sd1 <<< FRAC;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [2:0]  REG_UNUSED  = 3'd7;
    localparam int          SETTLE      = 150;
    localparam longint      CYC_LIMIT   = 3000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    gammatone_allpole_band_filter u_top (.*);

    // predictor registers and state
    longint      rot_c, rot_s, ph_c, ph_s, pole_k, gain;
    int unsigned skip_cfg, skip_left;
    longint      osc_r, osc_i;
    longint      pr[4], pim[4];

    logic [31:0] band_q[$];
    int          errors;
    longint      cycles;
    int          rx_hold;
    bit          rx_no_idle;
    bit          tx_no_idle;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ---------------- fixed-point arithmetic ----------------
    function automatic longint sadd(longint a, longint b);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        if (s[64] && !s[63]) return I64MIN;
        if (!s[64] && s[63]) return I64MAX;
        return s[63:0];
    endfunction

    function automatic longint ssub(longint a, longint b);
        return sadd(a, (b == I64MIN) ? I64MAX : -b);
    endfunction

    function automatic longint sscale(longint a, int n);
        logic signed [67:0] p;
        p = a;
        p = p * n;
        if (p > I64MAX) return I64MAX;
        if (p < I64MIN) return I64MIN;
        return p[63:0];
    endfunction

    function automatic longint clamp(longint a, longint lim);
        if (a > lim) return lim;
        if (a < -lim - 1) return -lim - 1;
        return a;
    endfunction

    function automatic logic [63:0] magn(longint a);
        logic [63:0] m;
        m = a;
        if (a < 0) m = ~m + 64'd1;
        return m;
    endfunction

    function automatic longint from_magn(logic [63:0] m, bit neg);
        if (neg) begin
            if (m[63]) return I64MIN;
            return -longint'(m);
        end
        if (m[63]) return I64MAX;
        return longint'(m);
    endfunction

    function automatic longint qmul(longint a, longint c);
        logic [63:0] am, cm, hi, lo, low, hs, sum;
        bit neg;
        neg = (a < 0) != (c < 0);
        am  = magn(a);
        cm  = magn(c);
        hi  = (am >> 32) * cm;
        lo  = {32'd0, am[31:0]} * cm;
        low = (lo + (64'd1 << (FRAC - 1))) >> FRAC;
        if (hi > (64'hFFFF_FFFF_FFFF_FFFF >> (32 - FRAC)))
            return from_magn(64'hFFFF_FFFF_FFFF_FFFF, neg);
        hs  = hi << (32 - FRAC);
        sum = hs + low;
        if (sum < hs) sum = 64'hFFFF_FFFF_FFFF_FFFF;
        return from_magn(sum, neg);
    endfunction

    function automatic longint round_sh8(longint a);
        logic [63:0] m;
        m = magn(a);
        return from_magn((m >> 8) + {63'd0, m[7]}, a < 0);
    endfunction

    // ---------------- band predictor ----------------
    task automatic clear_band();
        osc_r = ONE_Q;
        osc_i = 0;
        for (int i = 0; i < 4; i++) begin
            pr[i]  = 0;
            pim[i] = 0;
        end
        skip_left = skip_cfg;
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] d);
        case (idx)
            REG_ROT_COS:     rot_c    = longint'($signed(d));
            REG_ROT_SIN:     rot_s    = longint'($signed(d));
            REG_PHASE_COS:   ph_c     = longint'($signed(d));
            REG_PHASE_SIN:   ph_s     = longint'($signed(d));
            REG_POLE_RADIUS: pole_k   = longint'({34'd0, d[29:0]});
            REG_OUTPUT_GAIN: gain     = longint'({32'd0, d});
            REG_OUTPUT_SKIP: skip_cfg = d[15:0];
            default: ;
        endcase
    endtask

    task automatic band_step(logic [1:0] kind, logic [15:0] smp_bits);
        longint smp, k2, k3, k4, phr, phi, xr, xi, p0r, p0i, ur, ui, w, nr, ni;
        if (kind == KIND_RESTART) begin
            clear_band();
            return;
        end
        if (kind == KIND_UNUSED) return;
        smp = (kind == KIND_SAMPLE) ? longint'($signed(smp_bits)) : 0;
        k2  = qmul(pole_k, pole_k);
        k3  = qmul(k2, pole_k);
        k4  = qmul(k3, pole_k);
        phr = clamp(ssub(qmul(osc_r, ph_c), qmul(osc_i, ph_s)), I32MAX);
        phi = clamp(sadd(qmul(osc_r, ph_s), qmul(osc_i, ph_c)), I32MAX);
        xr  = qmul(smp * 256, phr);
        xi  = qmul(smp * 256, phi);

        p0r = sadd(xr, sscale(qmul(pr[0], pole_k), 4));
        p0r = ssub(p0r, sscale(qmul(pr[1], k2), 6));
        p0r = sadd(p0r, sscale(qmul(pr[2], k3), 4));
        p0r = clamp(ssub(p0r, qmul(pr[3], k4)), POLE_LIM);
        p0i = sadd(xi, sscale(qmul(pim[0], pole_k), 4));
        p0i = ssub(p0i, sscale(qmul(pim[1], k2), 6));
        p0i = sadd(p0i, sscale(qmul(pim[2], k3), 4));
        p0i = clamp(ssub(p0i, qmul(pim[3], k4)), POLE_LIM);

        ur = sadd(sadd(pr[0], sscale(qmul(pr[1], pole_k), 4)), qmul(pr[2], k2));
        ui = sadd(sadd(pim[0], sscale(qmul(pim[1], pole_k), 4)), qmul(pim[2], k2));
        w  = ssub(qmul(ur, osc_r), qmul(ui, osc_i));
        w  = clamp(round_sh8(qmul(w, gain)), I32MAX);

        for (int i = 3; i >= 1; i--) begin
            pr[i]  = pr[i-1];
            pim[i] = pim[i-1];
        end
        pr[0]  = p0r;
        pim[0] = p0i;

        nr = clamp(ssub(qmul(osc_r, rot_c), qmul(osc_i, rot_s)), I32MAX);
        ni = clamp(sadd(qmul(osc_i, rot_c), qmul(osc_r, rot_s)), I32MAX);
        osc_r = nr;
        osc_i = ni;

        if (skip_left > 0) skip_left--;
        else band_q.push_back(w[31:0]);
    endtask

    // ---------------- channels ----------------
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (band_q.size() == 0) report("unexpected item", m_tdata, 32'd0);
            else if (m_tdata !== band_q[0]) report("value", m_tdata, band_q.pop_front());
            else void'(band_q.pop_front());
        end
    end

    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end else begin
                n = rx_no_idle ? 0 : $urandom_range(0, 5);
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && rx_hold == 0);
        end
    end

    task automatic send_item(logic [1:0] kind, logic [15:0] smp);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        band_step(kind, smp);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (band_q.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        set_reg(idx, d);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q30();
        return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        send_item(KIND_SAMPLE, 16'sh7FFF);
        send_item(KIND_SAMPLE, 16'sh8000);
        send_item(KIND_SAMPLE, 16'h0000);
        send_item(KIND_FLUSH, 16'hFFFF);
        send_item(KIND_UNUSED, 16'h1234);
        send_item(KIND_SAMPLE, 16'h5555);
        send_item(KIND_RESTART, 16'hAAAA);
        send_item(KIND_SAMPLE, 16'hFFFF);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_ROT_COS, 32'hC000_0000);
        write_reg(REG_ROT_SIN, 32'h4000_0000);
        write_reg(REG_PHASE_COS, 32'hC000_0000);
        write_reg(REG_PHASE_SIN, 32'h4000_0000);
        write_reg(REG_POLE_RADIUS, 32'hFFFF_FFFF);
        write_reg(REG_OUTPUT_GAIN, 32'h8000_0000);
        write_reg(REG_OUTPUT_SKIP, 32'h0000_0003);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(KIND_RESTART, 16'h0000);
        for (int i = 0; i < 8; i++)
            send_item(KIND_SAMPLE, (i % 2) ? 16'h8000 : 16'h7FFF);
        send_item(KIND_FLUSH, 16'h0000);
        send_item(KIND_FLUSH, 16'h0000);
        drain();
        // largest skip is written but never loaded by a restart
        write_reg(REG_OUTPUT_SKIP, 32'h0000_FFFF);
        write_reg(REG_OUTPUT_GAIN, 32'h0000_0000);
        send_item(KIND_SAMPLE, 16'h4000);
        drain();
        write_reg(REG_OUTPUT_SKIP, 32'h0000_0000);
        send_item(KIND_RESTART, 16'h0000);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_OUTPUT_GAIN, 32'h4000_0000);
        write_reg(REG_POLE_RADIUS, 32'h3000_0000);
        rx_hold    = 800;
        tx_no_idle = 1'b1;
        for (int i = 0; i < 12; i++) send_item(KIND_SAMPLE, 16'($urandom));
        tx_no_idle = 1'b0;
        drain();
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        real ang;
        for (int p = 0; p < phases; p++) begin
            if (p % 2) begin
                ang = $urandom_range(0, 6283) / 1000.0;
                write_reg(REG_ROT_COS, 32'($rtoi($cos(ang) * 1073741824.0)));
                write_reg(REG_ROT_SIN, 32'($rtoi($sin(ang) * 1073741824.0)));
                write_reg(REG_POLE_RADIUS, 32'h4000_0000 - $urandom_range(1, 32'h0400_0000));
            end else begin
                write_reg(REG_ROT_COS, rand_q30());
                write_reg(REG_ROT_SIN, rand_q30());
                write_reg(REG_POLE_RADIUS, $urandom_range(0, 32'h3FFF_FFFF));
            end
            write_reg(REG_PHASE_COS, rand_q30());
            write_reg(REG_PHASE_SIN, rand_q30());
            write_reg(REG_OUTPUT_GAIN, $urandom_range(0, 32'h8000_0000));
            write_reg(REG_OUTPUT_SKIP, $urandom_range(0, 6));
            rx_no_idle = (p == 2);
            tx_no_idle = (p == 2);
            send_item(KIND_RESTART, 16'h0000);
            for (int i = 0; i < per_phase; i++) begin
                case ($urandom_range(0, 99))
                    0:       send_item(KIND_RESTART, 16'($urandom));
                    1:       send_item(KIND_UNUSED, 16'($urandom));
                    2, 3, 4, 5, 6, 7, 8, 9:
                             send_item(KIND_FLUSH, 16'($urandom));
                    default: send_item(KIND_SAMPLE, 16'($urandom));
                endcase
            end
            rx_no_idle = 1'b0;
            tx_no_idle = 1'b0;
            drain();
        end
    endtask

    initial begin
        errors     = 0;
        rx_hold    = 0;
        rx_no_idle = 1'b0;
        tx_no_idle = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rot_c = ONE_Q; rot_s = 0; ph_c = ONE_Q; ph_s = 0;
        pole_k = 0; gain = ONE_Q; skip_cfg = 0;
        clear_band();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_phases(5, 245);

        if (errors == 0 && band_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
